// ===== rtl/v4mt_pkg.sv =====
`default_nettype none

package v4mt_pkg;

  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned NUM_COMP = 4;
  localparam int unsigned VEC_W    = ELEM_W * NUM_COMP;
  localparam int unsigned PROD_W   = 2 * ELEM_W;
  localparam int unsigned PAIR_W   = PROD_W + 1;
  localparam int unsigned SUM_W    = PROD_W + 2;
  localparam int unsigned REG_W    = 64;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [ELEM_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] Q_MIN = 32'h8000_0000;

  // identity in Q16.16, register 0 in the lowest slot
  localparam logic [NUM_REGS-1:0][REG_W-1:0] MAT_RESET = {
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000
  };

  typedef logic [NUM_COMP-1:0][ELEM_W-1:0] vec_t;

  typedef struct packed {
    logic en_p;
    logic en_s;
    logic en_c;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/v4mt_lane.sv =====
`default_nettype none

// one output column: products, pair sums, final sum with shift and saturation
module v4mt_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire v4mt_pkg::lane_ctl_t         ctl,
  input  wire v4mt_pkg::vec_t              vec,
  input  wire v4mt_pkg::vec_t              col,
  output logic [v4mt_pkg::ELEM_W-1:0]      res,
  output logic                             sat
);

  logic signed [v4mt_pkg::PROD_W-1:0] prod_r   [v4mt_pkg::NUM_COMP];
  logic signed [v4mt_pkg::PROD_W-1:0] prod_nxt [v4mt_pkg::NUM_COMP];
  logic signed [v4mt_pkg::PAIR_W-1:0] pair_r   [2];
  logic signed [v4mt_pkg::PAIR_W-1:0] pair_nxt [2];
  logic signed [v4mt_pkg::SUM_W-1:0]  sum;
  logic signed [v4mt_pkg::SUM_W-1:0]  sum_sh;
  logic [v4mt_pkg::SUM_W-v4mt_pkg::ELEM_W:0] sum_hi;
  logic                               fits;
  logic [v4mt_pkg::ELEM_W-1:0]        res_r;
  logic [v4mt_pkg::ELEM_W-1:0]        res_nxt;
  logic                               sat_r;
  logic                               sat_nxt;

  always_comb begin
    for (int i = 0; i < v4mt_pkg::NUM_COMP; i++) begin
      prod_nxt[i] = $signed(vec[i]) * $signed(col[i]);
    end
    for (int k = 0; k < 2; k++) begin
      pair_nxt[k] = v4mt_pkg::PAIR_W'(prod_r[2*k]) + v4mt_pkg::PAIR_W'(prod_r[2*k+1]);
    end
  end

  // floor shift, then keep the value only if bits above 31 are pure sign
  always_comb begin
    sum     = v4mt_pkg::SUM_W'(pair_r[0]) + v4mt_pkg::SUM_W'(pair_r[1]);
    sum_sh  = sum >>> FRAC_BITS;
    sum_hi  = sum_sh[v4mt_pkg::SUM_W-1:v4mt_pkg::ELEM_W-1];
    fits    = (sum_hi == '0) || (sum_hi == '1);
    sat_nxt = !fits;
    if (fits) begin
      res_nxt = sum_sh[v4mt_pkg::ELEM_W-1:0];
    end else if (sum_sh[v4mt_pkg::SUM_W-1]) begin
      res_nxt = v4mt_pkg::Q_MIN;
    end else begin
      res_nxt = v4mt_pkg::Q_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_p) begin
      for (int i = 0; i < v4mt_pkg::NUM_COMP; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
    end
    if (ctl.en_s) begin
      for (int k = 0; k < 2; k++) begin
        pair_r[k] <= pair_nxt[k];
      end
    end
    if (ctl.en_c) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule

`default_nettype wire

// ===== rtl/v4mt_merge.sv =====
`default_nettype none

// gathers the four columns and the saturation flags into the output register
module v4mt_merge (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire v4mt_pkg::vec_t                cols,
  input  wire logic [v4mt_pkg::NUM_COMP-1:0] sats,
  output v4mt_pkg::vec_t                     data,
  output logic                               clip
);

  v4mt_pkg::vec_t data_r;
  logic           clip_r;
  logic           clip_nxt;

  assign clip_nxt = |sats;

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= cols;
      clip_r <= clip_nxt;
    end
  end

  assign data = data_r;
  assign clip = clip_r;

endmodule

`default_nettype wire

// ===== rtl/vector4_matrix_transform.sv =====
`default_nettype none

// channel   | ports                         | payload
// ----------+-------------------------------+---------------------------------------
// in        | in_tvalid/in_tready/in_tdata  | x, y, z, w (signed Q16.16), x lowest
// out       | out_tvalid/out_tready/...     | x, y, z, w saturated; tuser = clipped
// cfg       | cfg_we/cfg_addr/cfg_wdata     | matrix register, index 2*row + col/2
//
// one request per clock sustained while out_tready stays high; out_tvalid rises after the
// accepting edge loads the product register, then the pair-sum, column and output registers
// every stage holds its own valid bit, so a stall at the output only fills the
// pipe and in_tready falls once all four stages hold a request
// synchronous active-low reset clears the valid bits and loads the identity matrix

module vector4_matrix_transform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [v4mt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [v4mt_pkg::REG_W-1:0]        cfg_wdata,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [v4mt_pkg::VEC_W-1:0]        in_tdata,   // in_x, in_y, in_z, in_w
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [v4mt_pkg::VEC_W-1:0]             out_tdata,  // out_x, out_y, out_z, out_w
  output logic                                   out_tuser   // clipped
);

  // matrix registers, row i columns 0/1 at 2*i, columns 2/3 at 2*i+1
  logic [v4mt_pkg::NUM_REGS-1:0][v4mt_pkg::REG_W-1:0] mat_r;
  logic [v4mt_pkg::NUM_REGS-1:0][v4mt_pkg::REG_W-1:0] mat_nxt;

  always_comb begin
    mat_nxt = mat_r;
    if (cfg_we) begin
      mat_nxt[cfg_addr] = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= v4mt_pkg::MAT_RESET;
    end else begin
      mat_r <= mat_nxt;
    end
  end

  // pipeline valid bits: products, pair sums, columns, output
  logic vp_r, vs_r, vc_r, vo_r;
  logic vp_nxt, vs_nxt, vc_nxt, vo_nxt;
  logic rdy_p, rdy_s, rdy_c, rdy_o;
  v4mt_pkg::lane_ctl_t ctl;
  logic en_o;

  // a stage may load when it is empty or its content moves on this cycle
  always_comb begin
    rdy_o    = !vo_r || out_tready;
    rdy_c    = !vc_r || rdy_o;
    rdy_s    = !vs_r || rdy_c;
    rdy_p    = !vp_r || rdy_s;
    en_o     = vc_r && rdy_o;
    ctl.en_c = vs_r && rdy_c;
    ctl.en_s = vp_r && rdy_s;
    ctl.en_p = in_tvalid && rdy_p;
    vp_nxt   = rdy_p ? in_tvalid : vp_r;
    vs_nxt   = rdy_s ? vp_r : vs_r;
    vc_nxt   = rdy_c ? vs_r : vc_r;
    vo_nxt   = rdy_o ? vc_r : vo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
      vs_r <= 1'b0;
      vc_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      vp_r <= vp_nxt;
      vs_r <= vs_nxt;
      vc_r <= vc_nxt;
      vo_r <= vo_nxt;
    end
  end

  // one lane per output column, each sees the whole input vector
  v4mt_pkg::vec_t                 vec;
  v4mt_pkg::vec_t                 cols;
  logic [v4mt_pkg::NUM_COMP-1:0]  sats;

  assign vec = in_tdata;

  for (genvar j = 0; j < v4mt_pkg::NUM_COMP; j++) begin : g_lane
    v4mt_pkg::vec_t col;

    // column j of the matrix, one element per row
    for (genvar i = 0; i < v4mt_pkg::NUM_COMP; i++) begin : g_row
      assign col[i] = mat_r[2*i + j/2][v4mt_pkg::ELEM_W*(j%2) +: v4mt_pkg::ELEM_W];
    end

    v4mt_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .ctl (ctl),
      .vec (vec),
      .col (col),
      .res (cols[j]),
      .sat (sats[j])
    );
  end

  v4mt_pkg::vec_t out_data;
  logic           out_clip;

  v4mt_merge u_merge (
    .clk  (clk),
    .en   (en_o),
    .cols (cols),
    .sats (sats),
    .data (out_data),
    .clip (out_clip)
  );

  assign in_tready  = rdy_p;
  assign out_tvalid = vo_r;
  assign out_tdata  = out_data;
  assign out_tuser  = out_clip;

endmodule

`default_nettype wire

// ===== rtl/v4mt_checker.sv =====
`default_nettype none

module v4mt_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tvalid,
  input wire logic                         in_tready,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [v4mt_pkg::VEC_W-1:0]   out_tdata,
  input wire logic                         out_tuser
);

  // nothing comes out of reset as a pending result
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // a waiting request only stalls when the output side is stalled
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a stalled output");

  // clipped means at least one component sits at a saturation limit
  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[31:0]   == v4mt_pkg::Q_MAX || out_tdata[31:0]   == v4mt_pkg::Q_MIN ||
      out_tdata[63:32]  == v4mt_pkg::Q_MAX || out_tdata[63:32]  == v4mt_pkg::Q_MIN ||
      out_tdata[95:64]  == v4mt_pkg::Q_MAX || out_tdata[95:64]  == v4mt_pkg::Q_MIN ||
      out_tdata[127:96] == v4mt_pkg::Q_MAX || out_tdata[127:96] == v4mt_pkg::Q_MIN)
    else $error("clipped set with no saturated component");

endmodule

bind vector4_matrix_transform v4mt_checker u_v4mt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC_BITS       = 16;
  localparam int unsigned PIPE_LAT        = 3;       // accept to out_tvalid
  localparam int unsigned CYCLE_LIMIT     = 400000;  // far above the slowest legal run
  localparam int unsigned RAND_PHASES     = 6;
  localparam int unsigned ITEMS_PER_PHASE = 125;

  // matrix register map, index = 2*row + col/2
  typedef enum logic [v4mt_pkg::CFG_ADDR_W-1:0] {
    ROW0_COLS01, ROW0_COLS23, ROW1_COLS01, ROW1_COLS23,
    ROW2_COLS01, ROW2_COLS23, ROW3_COLS01, ROW3_COLS23
  } mat_reg_t;

  // m[row][col], one Q16.16 element each
  typedef logic [v4mt_pkg::NUM_COMP-1:0][v4mt_pkg::NUM_COMP-1:0][v4mt_pkg::ELEM_W-1:0] mat4_t;

  typedef struct packed {
    v4mt_pkg::vec_t comp;
    logic           clipped;
  } xform_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            cfg_we     = 1'b0;
  logic [v4mt_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [v4mt_pkg::REG_W-1:0]      cfg_wdata  = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [v4mt_pkg::VEC_W-1:0]      in_tdata   = '0;   // x, y, z, w from bit 0 up
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [v4mt_pkg::VEC_W-1:0]      out_tdata;         // x, y, z, w from bit 0 up
  logic                            out_tuser;         // clipped

  // shadow of the matrix registers as the block should hold them
  logic [v4mt_pkg::NUM_REGS-1:0][v4mt_pkg::REG_W-1:0] mat_regs = v4mt_pkg::MAT_RESET;

  v4mt_pkg::vec_t vec_backlog[$];   // requests not yet offered to the block
  xform_t         xform_due[$];     // transformed vectors still owed by the block

  int unsigned issued      = 0;
  int unsigned accepted    = 0;
  int unsigned errors      = 0;
  int unsigned cycle_count = 0;
  int unsigned src_wait    = 0;
  int unsigned snk_wait    = 0;
  bit          in_taken    = 1'b0;   // set at the rising edge, consumed at the falling one
  bit          out_taken   = 1'b0;
  bit          src_idle_en = 1'b1;
  bit          snk_idle_en = 1'b1;

  vector4_matrix_transform #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // element m[row][col] as the shadow registers hold it
  function automatic logic [v4mt_pkg::ELEM_W-1:0] mat_elem(int row, int col);
    return mat_regs[2 * row + col / 2][v4mt_pkg::ELEM_W * (col % 2) +: v4mt_pkg::ELEM_W];
  endfunction

  // exact sum of four full products, floor shift, then saturate each column
  function automatic xform_t transform_vec(v4mt_pkg::vec_t v);
    xform_t                              r;
    logic signed [v4mt_pkg::SUM_W+1:0]   acc;
    logic signed [v4mt_pkg::SUM_W+1:0]   lim_hi;
    logic signed [v4mt_pkg::SUM_W+1:0]   lim_lo;
    logic signed [v4mt_pkg::PROD_W-1:0]  a;
    logic signed [v4mt_pkg::PROD_W-1:0]  b;
    lim_hi    = $signed(v4mt_pkg::Q_MAX);
    lim_lo    = $signed(v4mt_pkg::Q_MIN);
    r.clipped = 1'b0;
    for (int col = 0; col < v4mt_pkg::NUM_COMP; col++) begin
      acc = '0;
      for (int row = 0; row < v4mt_pkg::NUM_COMP; row++) begin
        a   = $signed(v[row]);
        b   = $signed(mat_elem(row, col));
        acc = acc + a * b;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > lim_hi) begin
        r.comp[col] = v4mt_pkg::Q_MAX;
        r.clipped   = 1'b1;
      end else if (acc < lim_lo) begin
        r.comp[col] = v4mt_pkg::Q_MIN;
        r.clipped   = 1'b1;
      end else begin
        r.comp[col] = acc[v4mt_pkg::ELEM_W-1:0];
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  // idle cycles before the next request or result, none when idling is off
  function automatic int unsigned draw_wait(bit en);
    if (!en || $urandom_range(0, 3) == 0)
      return 0;
    return $urandom_range(0, 11);
  endfunction

  // mix of extremes, zero, small magnitudes and full-range noise
  function automatic logic [v4mt_pkg::ELEM_W-1:0] rand_q();
    case ($urandom_range(0, 9))
      0:       return v4mt_pkg::Q_MAX;
      1:       return v4mt_pkg::Q_MIN;
      2:       return '0;
      3, 4, 5: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;  // within +-8.0
      default: return $urandom();
    endcase
  endfunction

  function automatic mat4_t fill_mat(logic [v4mt_pkg::ELEM_W-1:0] val);
    mat4_t m;
    for (int row = 0; row < v4mt_pkg::NUM_COMP; row++)
      for (int col = 0; col < v4mt_pkg::NUM_COMP; col++)
        m[row][col] = val;
    return m;
  endfunction

  task automatic write_reg(input mat_reg_t idx, input logic [v4mt_pkg::REG_W-1:0] val);
    @(negedge clk);
    cfg_we        <= 1'b1;
    cfg_addr      <= idx;
    cfg_wdata     <= val;
    mat_regs[idx]  = val;
  endtask

  // only called with the pipe empty
  task automatic load_matrix(input mat4_t m);
    write_reg(ROW0_COLS01, {m[0][1], m[0][0]});
    write_reg(ROW0_COLS23, {m[0][3], m[0][2]});
    write_reg(ROW1_COLS01, {m[1][1], m[1][0]});
    write_reg(ROW1_COLS23, {m[1][3], m[1][2]});
    write_reg(ROW2_COLS01, {m[2][1], m[2][0]});
    write_reg(ROW2_COLS23, {m[2][3], m[2][2]});
    write_reg(ROW3_COLS01, {m[3][1], m[3][0]});
    write_reg(ROW3_COLS23, {m[3][3], m[3][2]});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_vec(input logic [v4mt_pkg::ELEM_W-1:0] x,
                           input logic [v4mt_pkg::ELEM_W-1:0] y,
                           input logic [v4mt_pkg::ELEM_W-1:0] z,
                           input logic [v4mt_pkg::ELEM_W-1:0] w);
    v4mt_pkg::vec_t v;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    v[3] = w;
    vec_backlog.push_back(v);
    issued++;
  endtask

  // sender holds off until every owed result has come back
  task automatic wait_drain();
    while (accepted != issued || xform_due.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: one request offered at a time, random gap after each acceptance
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_in
    logic nxt_valid;
    nxt_valid = in_tvalid;
    if (rst_n) begin
      if (in_taken) begin
        in_taken  = 1'b0;
        nxt_valid = 1'b0;
        src_wait  = draw_wait(src_idle_en);
      end
      if (!nxt_valid) begin
        if (src_wait > 0) begin
          src_wait--;
        end else if (vec_backlog.size() > 0) begin
          in_tdata  <= vec_backlog.pop_front();
          nxt_valid  = 1'b1;
        end
      end
      // single assignment so a back-to-back request keeps tvalid high
      in_tvalid <= nxt_valid;
    end
  end

  // result side back-pressure, a fresh stall drawn after each result
  always @(negedge clk) begin : drive_out
    if (rst_n) begin
      if (out_taken) begin
        out_taken = 1'b0;
        snk_wait  = draw_wait(snk_idle_en);
      end
      if (snk_wait > 0) begin
        snk_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check results, predict accepted requests, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    xform_t         want;
    v4mt_pkg::vec_t got;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_n) begin
      // results first, a request accepted on the same edge is owed later
      if (out_tvalid && out_tready) begin
        out_taken = 1'b1;
        got       = out_tdata;
        if (xform_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing owed: %h/%b", out_tdata, out_tuser));
        end else begin
          want = xform_due.pop_front();
          for (int k = 0; k < v4mt_pkg::NUM_COMP; k++)
            if (got[k] !== want.comp[k])
              report_mismatch($sformatf("component %0d got %h want %h",
                                        k, got[k], want.comp[k]));
          if (out_tuser !== want.clipped)
            report_mismatch($sformatf("clipped got %b want %b", out_tuser, want.clipped));
        end
      end
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        accepted++;
        xform_due.push_back(transform_vec(in_tdata));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    mat4_t m;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // identity straight out of reset: values pass through unchanged
    queue_vec('0, '0, '0, '0);
    queue_vec(v4mt_pkg::Q_MAX, v4mt_pkg::Q_MAX, v4mt_pkg::Q_MAX, v4mt_pkg::Q_MAX);
    queue_vec(v4mt_pkg::Q_MIN, v4mt_pkg::Q_MIN, v4mt_pkg::Q_MIN, v4mt_pkg::Q_MIN);
    queue_vec(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_vec(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_vec(32'h0001_0000, 32'hFFFF_0000, 32'h0001_8000, 32'h0001_0000);
    queue_vec(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, '0);   // normal, w of zero
    queue_vec(32'hFFFF_FFFF, 32'h0000_0001, v4mt_pkg::Q_MAX, v4mt_pkg::Q_MIN);
    wait_drain();

    // every element at the positive extreme: saturation both ways
    load_matrix(fill_mat(v4mt_pkg::Q_MAX));
    queue_vec(v4mt_pkg::Q_MAX, v4mt_pkg::Q_MAX, v4mt_pkg::Q_MAX, v4mt_pkg::Q_MAX);
    queue_vec(v4mt_pkg::Q_MIN, v4mt_pkg::Q_MIN, v4mt_pkg::Q_MIN, v4mt_pkg::Q_MIN);
    queue_vec(32'h0001_0000, '0, '0, '0);    // lands exactly on the top of range
    queue_vec(v4mt_pkg::Q_MAX, v4mt_pkg::Q_MIN, '0, '0);
    wait_drain();

    // every element at the negative extreme: the widest possible sum
    load_matrix(fill_mat(v4mt_pkg::Q_MIN));
    queue_vec(v4mt_pkg::Q_MIN, v4mt_pkg::Q_MIN, v4mt_pkg::Q_MIN, v4mt_pkg::Q_MIN);
    queue_vec(v4mt_pkg::Q_MAX, v4mt_pkg::Q_MAX, v4mt_pkg::Q_MAX, v4mt_pkg::Q_MAX);
    queue_vec(32'hFFFF_0000, '0, '0, '0);    // one past the top, just clips
    queue_vec(32'h0001_0000, '0, '0, '0);    // exactly the bottom, no clip
    wait_drain();

    // mixed fractions and extremes: floor rounding and one-column clipping
    m       = '0;
    m[0][0] = 32'h0000_8000;
    m[0][1] = 32'hFFFF_8000;
    m[0][2] = v4mt_pkg::Q_MAX;
    m[0][3] = v4mt_pkg::Q_MIN;
    m[1][0] = 32'h0001_0000;
    m[1][3] = 32'hFFFF_0000;
    m[2][1] = 32'h0001_0000;
    m[2][2] = 32'h0002_0000;
    m[3][0] = 32'h0003_0000;
    m[3][3] = 32'h0001_0000;
    load_matrix(m);
    queue_vec(32'hFFFF_FFFF, '0, '0, '0);    // tiny negative rounds down to -1 lsb
    queue_vec(32'h0000_0001, '0, '0, '0);
    queue_vec(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    queue_vec('0, '0, '0, 32'h0001_0000);    // translation row alone
    queue_vec(32'h0001_0000, 32'h0001_0000, '0, '0);
    queue_vec(v4mt_pkg::Q_MAX, v4mt_pkg::Q_MAX, v4mt_pkg::Q_MAX, v4mt_pkg::Q_MAX);
    wait_drain();

    // random phases, each under its own matrix and idling pattern
    for (int p = 0; p < RAND_PHASES; p++) begin
      src_idle_en = (p % 4 == 0) || (p % 4 == 2);
      snk_idle_en = (p % 4 == 0) || (p % 4 == 3);
      case (p)
        1:       m = fill_mat('0);
        2: begin
          for (int row = 0; row < v4mt_pkg::NUM_COMP; row++)
            for (int col = 0; col < v4mt_pkg::NUM_COMP; col++)
              m[row][col] = $urandom();      // every register bit toggles
        end
        3:       m = fill_mat(32'hFFFF_FFFF);
        5: begin
          m = '0;                            // back to identity
          for (int k = 0; k < v4mt_pkg::NUM_COMP; k++)
            m[k][k] = 32'h0001_0000;
        end
        default: begin
          for (int row = 0; row < v4mt_pkg::NUM_COMP; row++)
            for (int col = 0; col < v4mt_pkg::NUM_COMP; col++)
              m[row][col] = rand_q();
        end
      endcase
      load_matrix(m);
      // roughly one in five requests is a normal
      repeat (ITEMS_PER_PHASE)
        queue_vec(rand_q(), rand_q(), rand_q(),
                  ($urandom_range(0, 4) == 0) ? '0 : rand_q());
      wait_drain();
    end

    // let anything stray fall out of the pipe
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (xform_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", xform_due.size()));
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/v4mt_pkg.sv
rtl/v4mt_lane.sv
rtl/v4mt_merge.sv
rtl/vector4_matrix_transform.sv
rtl/v4mt_checker.sv
dv/tb.sv
